// File: hw/rtl/mma_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mma_pkg
// Shared widths, register indexes and controller/datapath bundles for the
// masked multilook averager.
// ----------------------------------------------------------------------------
package mma_pkg;

  // field and accumulator widths
  localparam int SAMPLE_W     = 32;
  localparam int SUM_W        = 44;
  localparam int CNT_W        = 13;
  localparam int LW_W         = 13;
  localparam int LOOK_W       = 7;
  localparam int COL_W        = 12;
  localparam int SUB_W        = 6;
  localparam int IDX_W        = 2;

  // limits and reset values
  localparam int MAX_LINE     = 4096;
  localparam int MAX_COL_LOOK = 64;
  localparam int MAX_ROW_LOOK = 64;
  localparam int LW_RESET     = 1024;

  // divider sizing, one quotient bit per step
  localparam int DIV_STEPS    = SUM_W;
  localparam int DIV_CNT_W    = 6;

  // accumulator entry: band a sum, band b sum, valid tally
  localparam int ACC_W        = 2 * SUM_W + CNT_W;

  // register indexes
  localparam logic [IDX_W-1:0] REG_LINE_WIDTH = 2'd0;
  localparam logic [IDX_W-1:0] REG_COLS_LOOK  = 2'd1;
  localparam logic [IDX_W-1:0] REG_ROWS_LOOK  = 2'd2;
  localparam logic [IDX_W-1:0] REG_THRESHOLD  = 2'd3;

  // controller to datapath commands
  typedef struct packed {
    logic accept;
    logic rmw;
    logic div_start;
    logic load_out;
  } ctl_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic emit;
    logic div_done;
    logic out_busy;
  } ctl_sts_t;

endpackage

// File: hw/rtl/mma_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mma_in_if
// Pixel input channel: valid/ready handshake with a two-band sample pair.
// ----------------------------------------------------------------------------
interface mma_in_if import mma_pkg::*; ;
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] band_a;
  logic signed [SAMPLE_W-1:0] band_b;

  modport source (output valid, output band_a, output band_b, input ready);
  modport sink   (input valid, input band_a, input band_b, output ready);
endinterface

// File: hw/rtl/mma_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mma_out_if
// Result channel: valid/ready handshake with one averaged output pixel.
// ----------------------------------------------------------------------------
interface mma_out_if import mma_pkg::*; ;
  logic                       valid;
  logic                       ready;
  logic        [COL_W-1:0]    out_column;
  logic signed [SAMPLE_W-1:0] mean_a;
  logic signed [SAMPLE_W-1:0] mean_b;
  logic        [CNT_W-1:0]    valid_count;
  logic                       line_end;

  modport source (output valid, output out_column, output mean_a, output mean_b,
                  output valid_count, output line_end, input ready);
  modport sink   (input valid, input out_column, input mean_a, input mean_b,
                  input valid_count, input line_end, output ready);
endinterface

// File: hw/rtl/mma_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mma_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mma_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// File: hw/rtl/mma_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mma_div
// Signed sum by unsigned tally, restoring division, one quotient bit per
// cycle, truncating toward zero.
// ----------------------------------------------------------------------------
module mma_div import mma_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic signed [SUM_W-1:0]    dividend,
  input  logic        [CNT_W-1:0]    divisor,
  output logic                       done,
  output logic signed [SAMPLE_W-1:0] quotient
);

  logic                 run_r, run_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W:0]       rem_r, rem_nxt;
  logic [SUM_W-1:0]     dq_r, dq_nxt;
  logic [CNT_W-1:0]     den_r, den_nxt;
  logic                 neg_r, neg_nxt;
  logic [CNT_W:0]       trial;
  logic                 ge;

  // one restoring step
  assign trial = {rem_r[CNT_W-1:0], dq_r[SUM_W-1]};
  assign ge    = (trial >= {1'b0, den_r});

  always_comb begin
    run_nxt  = run_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dq_nxt   = dq_r;
    den_nxt  = den_r;
    neg_nxt  = neg_r;
    if (start) begin
      run_nxt = 1'b1;
      cnt_nxt = '0;
      rem_nxt = '0;
      dq_nxt  = dividend[SUM_W-1] ? (SUM_W'(0) - dividend) : dividend;
      den_nxt = divisor;
      neg_nxt = dividend[SUM_W-1];
    end else if (run_r) begin
      rem_nxt = ge ? (trial - {1'b0, den_r}) : trial;
      dq_nxt  = {dq_r[SUM_W-2:0], ge};
      cnt_nxt = cnt_r + DIV_CNT_W'(1);
      if (cnt_r == DIV_CNT_W'(DIV_STEPS - 1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dq_r  <= dq_nxt;
    den_r <= den_nxt;
    neg_r <= neg_nxt;
  end

  assign done     = done_r;
  assign quotient = neg_r ? (SAMPLE_W'(0) - dq_r[SAMPLE_W-1:0]) : dq_r[SAMPLE_W-1:0];

endmodule

// File: hw/rtl/mma_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mma_datapath
// Configuration registers, raster position counters, per-column accumulator
// memory, the two mean dividers and the result register.
// ----------------------------------------------------------------------------
module mma_datapath import mma_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_wr_en,
  input  logic [IDX_W-1:0]           cfg_index,
  input  logic [SAMPLE_W-1:0]        cfg_data,
  input  logic signed [SAMPLE_W-1:0] in_band_a,
  input  logic signed [SAMPLE_W-1:0] in_band_b,
  input  ctl_cmd_t                   cmd,
  output ctl_sts_t                   sts,
  input  logic                       out_ready,
  output logic                       out_valid,
  output logic [COL_W-1:0]           out_column,
  output logic signed [SAMPLE_W-1:0] mean_a,
  output logic signed [SAMPLE_W-1:0] mean_b,
  output logic [CNT_W-1:0]           valid_count,
  output logic                       line_end
);

  // configuration; line width and look counts are stored already clamped
  logic [LW_W-1:0]            lw_r;
  logic [LOOK_W-1:0]          cpl_r;
  logic [LOOK_W-1:0]          rpl_r;
  logic signed [SAMPLE_W-1:0] thr_r;

  // raster position
  logic [COL_W-1:0] col_r, col_nxt;
  logic [SUB_W-1:0] sub_r, sub_nxt;
  logic [COL_W-1:0] box_r, box_nxt;
  logic [COL_W-1:0] oc_r, oc_nxt;
  logic [SUB_W-1:0] row_r, row_nxt;

  // pixel held for the read-modify-write
  logic signed [SAMPLE_W-1:0] p_a_r, p_b_r;
  logic                       p_ok_r, p_fit_r, p_last_r, p_first_r, p_lend_r;
  logic [COL_W-1:0]           p_oc_r;

  // result waiting on the dividers
  logic [COL_W-1:0] res_oc_r;
  logic [CNT_W-1:0] res_n_r;
  logic             res_lend_r;

  // output register
  logic                       out_valid_r;
  logic [COL_W-1:0]           out_column_r;
  logic signed [SAMPLE_W-1:0] mean_a_r, mean_b_r;
  logic [CNT_W-1:0]           valid_count_r;
  logic                       line_end_r;

  logic                       fit, lend, last_col, last_row, col_wrap;
  logic [ACC_W-1:0]           rd_data, wr_data;
  logic signed [SUM_W-1:0]    base_a, base_b, new_a, new_b;
  logic [CNT_W-1:0]           base_n, new_n;
  logic                       done_a, done_b;
  logic signed [SAMPLE_W-1:0] q_a, q_b;

  function automatic logic [LW_W-1:0] clamp_lw(input logic [LW_W-1:0] v);
    if (v == '0) return LW_W'(1);
    if (v > LW_W'(MAX_LINE)) return LW_W'(MAX_LINE);
    return v;
  endfunction

  function automatic logic [LOOK_W-1:0] clamp_look(input logic [LOOK_W-1:0] v,
                                                   input logic [LOOK_W-1:0] hi);
    if (v == '0) return LOOK_W'(1);
    if (v > hi) return hi;
    return v;
  endfunction

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lw_r  <= LW_W'(LW_RESET);
      cpl_r <= LOOK_W'(1);
      rpl_r <= LOOK_W'(1);
      thr_r <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_LINE_WIDTH: lw_r  <= clamp_lw(cfg_data[LW_W-1:0]);
        REG_COLS_LOOK:  cpl_r <= clamp_look(cfg_data[LOOK_W-1:0], LOOK_W'(MAX_COL_LOOK));
        REG_ROWS_LOOK:  rpl_r <= clamp_look(cfg_data[LOOK_W-1:0], LOOK_W'(MAX_ROW_LOOK));
        REG_THRESHOLD:  thr_r <= cfg_data;
        default:        thr_r <= thr_r;
      endcase
    end
  end

  // box geometry of the current pixel
  assign fit      = ({1'b0, box_r} + {{(LW_W-LOOK_W){1'b0}}, cpl_r}) <= lw_r;
  assign lend     = ({2'b0, box_r} + {{(LW_W-LOOK_W){1'b0}}, cpl_r, 1'b0})
                    > {1'b0, lw_r};
  assign last_col = ({1'b0, sub_r} == (cpl_r - LOOK_W'(1)));
  assign last_row = ({1'b0, row_r} == (rpl_r - LOOK_W'(1)));
  assign col_wrap = ({1'b0, col_r} + LW_W'(1)) >= lw_r;

  // position advance on each accepted pixel
  always_comb begin
    col_nxt = col_r;
    sub_nxt = sub_r;
    box_nxt = box_r;
    oc_nxt  = oc_r;
    row_nxt = row_r;
    if (cmd.accept) begin
      if (col_wrap) begin
        col_nxt = '0;
        sub_nxt = '0;
        box_nxt = '0;
        oc_nxt  = '0;
        row_nxt = last_row ? '0 : row_r + SUB_W'(1);
      end else begin
        col_nxt = col_r + COL_W'(1);
        if (last_col) begin
          sub_nxt = '0;
          box_nxt = col_r + COL_W'(1);
          oc_nxt  = oc_r + COL_W'(1);
        end else begin
          sub_nxt = sub_r + SUB_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cfg_wr_en) begin
      col_r <= '0;
      sub_r <= '0;
      box_r <= '0;
      oc_r  <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      sub_r <= sub_nxt;
      box_r <= box_nxt;
      oc_r  <= oc_nxt;
      row_r <= row_nxt;
    end
  end

  // capture the pixel and its box flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_fit_r  <= 1'b0;
      p_last_r <= 1'b0;
    end else if (cmd.accept) begin
      p_fit_r  <= fit;
      p_last_r <= last_col && last_row;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      p_a_r     <= in_band_a;
      p_b_r     <= in_band_b;
      p_ok_r    <= in_band_a > thr_r;
      p_first_r <= (row_r == '0) && (sub_r == '0);
      p_oc_r    <= oc_r;
      p_lend_r  <= lend;
    end
  end

  // accumulator memory, read at the current output column every cycle
  mma_ram #(
    .WIDTH (ACC_W),
    .DEPTH (MAX_LINE)
  ) u_acc (
    .clk     (clk),
    .wr_en   (cmd.rmw && p_fit_r),
    .wr_addr (p_oc_r),
    .wr_data (wr_data),
    .rd_addr (oc_r),
    .rd_data (rd_data)
  );

  // the first line of a band starts each box from zero
  assign base_a = p_first_r ? '0 : rd_data[ACC_W-1 -: SUM_W];
  assign base_b = p_first_r ? '0 : rd_data[CNT_W +: SUM_W];
  assign base_n = p_first_r ? '0 : rd_data[CNT_W-1:0];

  assign new_a = base_a + (p_ok_r ? {{(SUM_W-SAMPLE_W){p_a_r[SAMPLE_W-1]}}, p_a_r} : '0);
  assign new_b = base_b + (p_ok_r ? {{(SUM_W-SAMPLE_W){p_b_r[SAMPLE_W-1]}}, p_b_r} : '0);
  assign new_n = base_n + {{(CNT_W-1){1'b0}}, p_ok_r};

  // emitted boxes leave a cleared entry behind
  assign wr_data = (p_fit_r && p_last_r) ? '0 : {new_a, new_b, new_n};

  // mean dividers
  mma_div u_div_a (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (new_a),
    .divisor  (new_n),
    .done     (done_a),
    .quotient (q_a)
  );

  mma_div u_div_b (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (new_b),
    .divisor  (new_n),
    .done     (done_b),
    .quotient (q_b)
  );

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      res_oc_r   <= p_oc_r;
      res_n_r    <= new_n;
      res_lend_r <= p_lend_r;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_column_r  <= res_oc_r;
      mean_a_r      <= (res_n_r == '0) ? '0 : q_a;
      mean_b_r      <= (res_n_r == '0) ? '0 : q_b;
      valid_count_r <= res_n_r;
      line_end_r    <= res_lend_r;
    end
  end

  assign sts.emit     = p_fit_r && p_last_r;
  assign sts.div_done = done_a && done_b;
  assign sts.out_busy = out_valid_r && !out_ready;

  assign out_valid   = out_valid_r;
  assign out_column  = out_column_r;
  assign mean_a      = mean_a_r;
  assign mean_b      = mean_b_r;
  assign valid_count = valid_count_r;
  assign line_end    = line_end_r;

endmodule

// File: hw/rtl/mma_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mma_ctrl
// Sequencer: accept a pixel, update its accumulator entry, and on a
// completed box run the dividers and hand the result to the output register.
// ----------------------------------------------------------------------------
module mma_ctrl import mma_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  ctl_sts_t sts,
  output ctl_cmd_t cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RMW  = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_LOAD = 2'd3;

  logic [1:0] state_r, state_nxt;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        cmd.accept = in_valid;
        if (in_valid) state_nxt = S_RMW;
      end
      S_RMW: begin
        cmd.rmw = 1'b1;
        if (sts.emit) begin
          cmd.div_start = 1'b1;
          state_nxt     = S_DIV;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_DIV: begin
        if (sts.div_done) state_nxt = S_LOAD;
      end
      S_LOAD: begin
        if (!sts.out_busy) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);

`ifndef ASSERT_OFF
  // dividers start only on a box-completing pixel
  a_div_start: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |-> (state_r == S_RMW) && sts.emit)
    else $error("divider started outside a completed box");

  // the sequencer holds while the dividers run
  a_div_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) && !sts.div_done |=> (state_r == S_DIV))
    else $error("left divide state before quotient ready");

  // a result never overwrites one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> !sts.out_busy)
    else $error("result register overwritten");

  // the sequencer never stays in the memory update state
  a_rmw_once: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RMW) |=> (state_r != S_RMW))
    else $error("accumulator update repeated");
`endif

endmodule

// File: hw/rtl/masked_multilook_averager_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// masked_multilook_averager_unit
// Masked multilook box averager: two-band raster pixels in, per-box means of
// the valid pixels out.
// ----------------------------------------------------------------------------
//  channel   | dir | handshake          | payload
//  ----------+-----+--------------------+----------------------------------------
//  in_ch     | in  | valid / ready      | band_a, band_b
//  out_ch    | out | valid / ready      | out_column, mean_a, mean_b,
//            |     |                    | valid_count, line_end
//  cfg_*     | in  | cfg_wr_en          | cfg_index, cfg_data
//
// a pixel that completes no box goes through accept, then the accumulator
// read-modify-write through the memory's read and write ports
// a box-completing pixel goes through accept, update, the 44 steps of the
// bit-serial dividers, the wait for done and the load of the result register
// no clearing pass after reset: the first line of each band starts its
// accumulator entries from zero; any register write restarts the stream
// the result register stays while out_ch is stalled; the next pixel is
// accepted meanwhile and only a further result waits for it to drain
// ----------------------------------------------------------------------------
module masked_multilook_averager_unit import mma_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  mma_in_if.sink            in_ch,
  mma_out_if.source         out_ch,
  input  logic              cfg_wr_en,
  input  logic [IDX_W-1:0]  cfg_index,
  input  logic [SAMPLE_W-1:0] cfg_data
);

  ctl_cmd_t cmd;
  ctl_sts_t sts;

  // sequencer
  mma_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath
  mma_datapath u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_band_a   (in_ch.band_a),
    .in_band_b   (in_ch.band_b),
    .cmd         (cmd),
    .sts         (sts),
    .out_ready   (out_ch.ready),
    .out_valid   (out_ch.valid),
    .out_column  (out_ch.out_column),
    .mean_a      (out_ch.mean_a),
    .mean_b      (out_ch.mean_b),
    .valid_count (out_ch.valid_count),
    .line_end    (out_ch.line_end)
  );

endmodule
